@@ rtl/core/deq_pkg.sv @@
// Shared types and codes for the double-ended queue unit.
// No dependencies; used by every module under rtl/core.
package deq_pkg;

   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_REAR  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_REAR   = 3'd3,
      REQ_DELETE     = 3'd4,
      REQ_GET        = 3'd5,
      REQ_CLEAR      = 3'd6,
      REQ_IGNORE     = 3'd7
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      req_kind_type        req_type;
      logic [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]  index;
   } deq_req_type;

   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  read_data;
      logic [VALUE_W-1:0]  front_value;
      logic [VALUE_W-1:0]  rear_value;
      logic [COUNT_W-1:0]  item_count;
      logic                is_empty;
   } deq_rsp_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

   // What every cell of the chain does on a clock edge.
   typedef enum logic [2:0] {
      CELL_HOLD,     // keep contents
      CELL_SHR,      // take left neighbor (front push)
      CELL_WRITE,    // cell at live_len takes the value (rear push)
      CELL_ROTATE,   // shift left, head wraps to live_len-1
      CELL_DROP      // shift left, head discarded
   } cell_op_type;

endpackage

@@ rtl/core/double_ended_queue_unit.sv @@
// Bounded double-ended queue: top level, cell chain plus sequencer.
// Depends on deq_pkg, deq_cell and deq_ctrl.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) carries one request beat: push front,
//    push rear, pop front, pop rear, delete first match, get by index, clear, ignore.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one beat per request:
//    status, read data, front and rear entries (0 when empty), count and empty flag.
//  - Entries sit in a row of DEPTH cells in front-to-rear order; cell 0 is the front.
//    Front push shifts the row right, front pop shifts it left, rear push writes the
//    cell at the current count.
//  - Delete, get and rear pop walk the queue: each cycle the head entry either wraps
//    to the end of the live region or is dropped, so after n steps (n = entries held)
//    the order is restored. The sequencer tracks the rear from the wrapping entries.
//  - rsp_valid is registered; push, front pop, clear and requests that fail up front
//    go straight to the result step, while delete, get and rear pop scan first.
//    One request is in flight at a time; a new beat is taken only when idle.
//  - req_ready is high whenever the sequencer is idle, even while a finished beat
//    waits on rsp; a receiver stall only holds the next result in the sequencer.
//  - Reset (synchronous, active high) empties the queue; no clearing pass is needed
//    since cells are only read inside the live region.
module double_ended_queue_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  deq_pkg::deq_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output deq_pkg::deq_rsp_type  rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   deq_pkg::cell_op_type  cell_op;
   logic [CW-1:0]         live_len;
   logic [DATA_WIDTH-1:0] cell_value;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   deq_ctrl #(
      .DEPTH (DEPTH),
      .DW    (DATA_WIDTH),
      .CW    (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .cell_op    (cell_op),
      .live_len   (live_len),
      .cell_value (cell_value),
      .head_data  (cell_data[0])
   );

   // Cell row; the front cell's left input is the pushed value and the rear cell
   // feeds back on itself as it never takes its right neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = cell_value;
      end else begin : g_mid
         assign left_w = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_inner
         assign right_w = cell_data[i+1];
      end

      deq_cell #(
         .DW  (DATA_WIDTH),
         .CW  (CW),
         .IDX (i)
      ) u_cell (
         .clock      (clock),
         .cell_op    (cell_op),
         .live_len   (live_len),
         .value      (cell_value),
         .left_data  (left_w),
         .right_data (right_w),
         .head_data  (cell_data[0]),
         .data_out   (cell_data[i])
      );
   end

endmodule

@@ rtl/core/deq_cell.sv @@
// One storage cell of the deque chain: holds one entry, position IDX from the front.
// Depends on deq_pkg.
module deq_cell #(
   parameter int DW  = 32,
   parameter int CW  = 5,
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  deq_pkg::cell_op_type  cell_op,
   input  logic [CW-1:0]         live_len,
   input  logic [DW-1:0]         value,
   input  logic [DW-1:0]         left_data,
   input  logic [DW-1:0]         right_data,
   input  logic [DW-1:0]         head_data,
   output logic [DW-1:0]         data_out
);

   logic [DW-1:0] data_ff;
   logic [DW-1:0] data_in;
   logic          at_len;
   logic          at_last;
   logic          below_last;

   assign at_len     = (live_len == CW'(IDX));
   assign at_last    = (live_len == CW'(IDX + 1));
   assign below_last = (32'(IDX + 1) < 32'(live_len));

   always_comb begin
      data_in = data_ff;
      case (cell_op)
         deq_pkg::CELL_HOLD:   data_in = data_ff;
         deq_pkg::CELL_SHR:    data_in = left_data;
         deq_pkg::CELL_WRITE: begin
            if (at_len) data_in = value;
         end
         deq_pkg::CELL_ROTATE: begin
            if (at_last)         data_in = head_data;
            else if (below_last) data_in = right_data;
         end
         deq_pkg::CELL_DROP: begin
            if (below_last) data_in = right_data;
         end
         default:              data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

@@ rtl/core/deq_ctrl.sv @@
// Sequencer for the deque: request decode, scan steps, count, rear and result register.
// Depends on deq_pkg; drives the cell chain built in the top level.
module deq_ctrl #(
   parameter int DEPTH = 16,
   parameter int DW    = 32,
   parameter int CW    = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  deq_pkg::deq_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output deq_pkg::deq_rsp_type  rsp_data,
   output deq_pkg::cell_op_type  cell_op,
   output logic [CW-1:0]         live_len,
   output logic [DW-1:0]         cell_value,
   input  logic [DW-1:0]         head_data
);

   deq_pkg::fsm_type        state_ff, state_in;
   deq_pkg::req_kind_type   kind_ff, kind_in;
   deq_pkg::status_type     status_ff, status_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           scan_ff, scan_in;
   logic [CW-1:0]           last_ff, last_in;
   logic [DW-1:0]           val_ff, val_in;
   logic [DW-1:0]           rd_ff, rd_in;
   logic [DW-1:0]           rear_ff, rear_in;
   logic [deq_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic                    found_ff, found_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   deq_pkg::deq_rsp_type    rsp_ff, rsp_in;

   logic [63:0]             val_wide;
   logic [DW-1:0]           req_val;
   logic [63:0]             front_wide;
   logic [63:0]             rear_wide;
   logic [63:0]             rd_wide;
   logic                    is_full;
   logic                    is_empty;
   logic                    drop;
   logic                    at_end;

   assign val_wide   = 64'(req_data.value);
   assign req_val    = val_wide[DW-1:0];
   assign front_wide = 64'(head_data);
   assign rear_wide  = 64'(rear_ff);
   assign rd_wide    = 64'(rd_ff);
   assign is_full    = (count_ff == CW'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign at_end     = (scan_ff == last_ff);

   assign drop = ((kind_ff == deq_pkg::REQ_POP_REAR) && at_end) ||
                 ((kind_ff == deq_pkg::REQ_DELETE) && !found_ff && (head_data == val_ff));

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      last_in      = last_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      rear_in      = rear_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cell_op      = deq_pkg::CELL_HOLD;
      live_len     = count_ff;
      cell_value   = req_val;

      case (state_ff)
         deq_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = req_data.req_type;
               val_in    = req_val;
               idx_in    = req_data.index;
               found_in  = 1'b0;
               rd_in     = '0;
               status_in = deq_pkg::ST_DONE;
               scan_in   = '0;
               last_in   = count_ff - CW'(1);
               state_in  = deq_pkg::FSM_DONE;
               case (req_data.req_type)
                  deq_pkg::REQ_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = deq_pkg::ST_FULL;
                     end else begin
                        cell_op  = deq_pkg::CELL_SHR;
                        count_in = count_ff + CW'(1);
                        if (is_empty) rear_in = req_val;
                     end
                  end
                  deq_pkg::REQ_PUSH_REAR: begin
                     if (is_full) begin
                        status_in = deq_pkg::ST_FULL;
                     end else begin
                        cell_op  = deq_pkg::CELL_WRITE;
                        count_in = count_ff + CW'(1);
                        rear_in  = req_val;
                     end
                  end
                  deq_pkg::REQ_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = deq_pkg::ST_EMPTY;
                     end else begin
                        cell_op  = deq_pkg::CELL_DROP;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  deq_pkg::REQ_POP_REAR: begin
                     if (is_empty) status_in = deq_pkg::ST_EMPTY;
                     else          state_in  = deq_pkg::FSM_SCAN;
                  end
                  deq_pkg::REQ_DELETE: begin
                     if (is_empty) status_in = deq_pkg::ST_MISS;
                     else          state_in  = deq_pkg::FSM_SCAN;
                  end
                  deq_pkg::REQ_GET: begin
                     if (32'(req_data.index) < 32'(count_ff)) state_in  = deq_pkg::FSM_SCAN;
                     else                                     status_in = deq_pkg::ST_MISS;
                  end
                  deq_pkg::REQ_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         deq_pkg::FSM_SCAN: begin
            // one original entry reaches the head each step
            if (drop) begin
               cell_op  = deq_pkg::CELL_DROP;
               count_in = count_ff - CW'(1);
               found_in = 1'b1;
            end else begin
               cell_op  = deq_pkg::CELL_ROTATE;
               rear_in  = head_data;
            end
            if ((kind_ff == deq_pkg::REQ_GET) && (32'(scan_ff) == 32'(idx_ff)))
               rd_in = head_data;
            if (at_end) begin
               state_in = deq_pkg::FSM_DONE;
               if ((kind_ff == deq_pkg::REQ_DELETE) && !(found_ff || drop))
                  status_in = deq_pkg::ST_MISS;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end

         deq_pkg::FSM_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.read_data   = rd_wide[deq_pkg::VALUE_W-1:0];
               rsp_in.front_value = is_empty ? '0 : front_wide[deq_pkg::VALUE_W-1:0];
               rsp_in.rear_value  = is_empty ? '0 : rear_wide[deq_pkg::VALUE_W-1:0];
               rsp_in.item_count  = deq_pkg::COUNT_W'(count_ff);
               rsp_in.is_empty    = is_empty;
               state_in           = deq_pkg::FSM_IDLE;
            end
         end

         default: state_in = deq_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      status_ff <= status_in;
      scan_ff   <= scan_in;
      last_ff   <= last_in;
      val_ff    <= val_in;
      rd_ff     <= rd_in;
      rear_ff   <= rear_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
